>>> src/idrt_pkg.sv
// Shared types and codes for the integer divide unit.
`default_nettype none
package idrt_pkg;
   localparam logic [1:0] FUNC_SDIV = 2'd0;
   localparam logic [1:0] FUNC_SREM = 2'd1;
   localparam logic [1:0] FUNC_UDIV = 2'd2;
   localparam logic [1:0] FUNC_UREM = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic       want_rem;
      logic       neg_out;
      logic [1:0] status;
   } ctl_type;
endpackage
`default_nettype wire

>>> src/int64_divide_remainder_trap_core.sv
// Pipelined signed and unsigned integer divider with remainder and status.
`default_nettype none
// One transaction enters per cycle while the result side is not stalled.
// The first stage takes the operand magnitudes and flags the special cases. Then DATA_WIDTH
// restoring stages each produce one quotient bit, with one subtract and compare per stage.
// The last stage restores the sign. A stall on the result side freezes the whole pipeline.
// A zero divisor gives status 1 and value 0. The signed quotient of the most negative
// value by -1 gives status 2 and value 0. The signed remainder of that pair is 0.
module int64_divide_remainder_trap_core #(
   parameter int DATA_WIDTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_func,
   input  wire  [63:0] req_dividend,
   input  wire  [63:0] req_divisor,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_value,
   output logic [1:0]  rsp_status
);
   import idrt_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam int S = W + 1;

   logic              adv;
   logic [W-1:0]      a_w, b_w, ma, mb;
   logic              neg_a, neg_b, sgn;
   ctl_type           ctl_in;

   logic [S-1:0]      vld_ff;
   ctl_type           ctl_ff [S];
   logic [W-1:0]      rem_ff [S];
   logic [W-1:0]      quo_ff [S];
   logic [W-1:0]      dvs_ff [S];

   logic              out_vld_ff;
   logic [W-1:0]      out_val_ff;
   logic [1:0]        out_sts_ff;
   logic [W-1:0]      res_in;

   assign adv = !(out_vld_ff && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      a_w = req_dividend[W-1:0];
      b_w = req_divisor[W-1:0];
      sgn = !req_func[1];
      neg_a = sgn && a_w[W-1];
      neg_b = sgn && b_w[W-1];
      ma = neg_a ? (~a_w + W'(1)) : a_w;
      mb = neg_b ? (~b_w + W'(1)) : b_w;
      ctl_in.want_rem = req_func[0];
      ctl_in.neg_out = req_func[0] ? neg_a : (neg_a ^ neg_b);
      if (b_w == '0) begin
         ctl_in.status = STATUS_DIV_ZERO;
      end else if (req_func == FUNC_SDIV && a_w == {1'b1, {(W-1){1'b0}}}
                   && b_w == '1) begin
         ctl_in.status = STATUS_OVERFLOW;
      end else begin
         ctl_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[S-2:0], req_valid};
         out_vld_ff <= vld_ff[S-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= ctl_in;
         rem_ff[0] <= '0;
         quo_ff[0] <= ma;
         dvs_ff[0] <= mb;
      end
   end

   for (genvar i = 1; i < S; i++) begin : g_step
      logic [W:0] trial;
      logic [W:0] diff;
      always_comb begin
         trial = {rem_ff[i-1], quo_ff[i-1][W-1]};
         diff = trial - {1'b0, dvs_ff[i-1]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            ctl_ff[i] <= ctl_ff[i-1];
            dvs_ff[i] <= dvs_ff[i-1];
            rem_ff[i] <= diff[W] ? trial[W-1:0] : diff[W-1:0];
            quo_ff[i] <= {quo_ff[i-1][W-2:0], !diff[W]};
         end
      end
   end

   always_comb begin
      res_in = ctl_ff[S-1].want_rem ? rem_ff[S-1] : quo_ff[S-1];
      if (ctl_ff[S-1].neg_out) begin
         res_in = ~res_in + W'(1);
      end
      if (ctl_ff[S-1].status != STATUS_OK) begin
         res_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_val_ff <= res_in;
         out_sts_ff <= ctl_ff[S-1].status;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_value = 64'(out_val_ff);
   assign rsp_status = out_sts_ff;

`ifndef SYNTHESIS
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_value == '0)
      else $error("nonzero value with error status");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("illegal status code");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("result changed under stall");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");
`endif
endmodule
`default_nettype wire

>>> tb/tb_int64_divide_remainder_trap_core.sv
// Self-checking testbench for the pipelined 64-bit signed and unsigned divider.
`timescale 1ns / 1ps
module tb_int64_divide_remainder_trap_core;
   import idrt_pkg::*;

   typedef struct {
      logic [63:0] value;
      logic [1:0]  status;
   } quot_rem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_SDIV;
   logic [63:0] req_dividend = '0;
   logic [63:0] req_divisor = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value;
   logic [1:0]  rsp_status;

   quot_rem_type pending_quot_rem[$];
   int          fail_count = 0;
   int          hold_cycles = 0;
   int          stall_mode = 1;
   bit          gaps_on = 1'b1;

   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   int64_divide_remainder_trap_core #(.DATA_WIDTH(64)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_dividend(req_dividend), .req_divisor(req_divisor),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic quot_rem_type divide_predict(logic [1:0] func, logic [63:0] a,
                                                   logic [63:0] b);
      quot_rem_type r;
      logic [63:0] ma, mb, q;
      r.value = '0;
      r.status = STATUS_OK;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      if (b == 0) begin
         r.status = STATUS_DIV_ZERO;
      end else if (func == FUNC_UDIV) begin
         r.value = a / b;
      end else if (func == FUNC_UREM) begin
         r.value = a % b;
      end else if (func == FUNC_SDIV) begin
         if (a == MOST_NEG && b == ALL_ONES) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            q = ma / mb;
            r.value = (a[63] != b[63]) ? -q : q;
         end
      end else begin
         q = ma % mb;
         r.value = a[63] ? -q : q;
      end
      return r;
   endfunction

   task automatic send_divide(logic [1:0] func, logic [63:0] a, logic [63:0] b);
      req_valid <= 1'b1;
      req_func <= func;
      req_dividend <= a;
      req_divisor <= b;
      do @(posedge clock); while (req_stall);
      pending_quot_rem.push_back(divide_predict(func, a, b));
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_quot_rem.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic [63:0] rand_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = v >> $urandom_range(0, 63);
         1: v = -(v >> $urandom_range(0, 63));
         2: v = {60'd0, v[3:0]};
         3: v = MOST_NEG;
         4: v = ALL_ONES;
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      quot_rem_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_quot_rem.size() == 0) begin
            $error("unexpected transaction value=%h status=%0d", rsp_value, rsp_status);
            fail_count++;
         end else begin
            exp_r = pending_quot_rem.pop_front();
            if (rsp_value !== exp_r.value) begin
               $error("value expected %h actual %h", exp_r.value, rsp_value);
               fail_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (stall_mode == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 4) == 0);
      end
   end

   task automatic test_directed();
      logic [63:0] vals[8];
      vals = '{64'd0, 64'd1, ALL_ONES, MOST_NEG, 64'h7FFF_FFFF_FFFF_FFFF, 64'd7,
               -64'd7, 64'd3};
      for (int f = 0; f < 4; f++) begin
         send_divide(f[1:0], vals[$urandom_range(1, 7)], 64'd0);
         send_divide(f[1:0], MOST_NEG, ALL_ONES);
         send_divide(f[1:0], -64'd7, 64'd2);
         send_divide(f[1:0], 64'd7, -64'd2);
         send_divide(f[1:0], 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
      end
      send_divide(FUNC_UDIV, ALL_ONES, ALL_ONES);
      send_divide(FUNC_UREM, 64'd0, ALL_ONES);
      drain_results();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) begin
            gaps_on = 1'($urandom_range(0, 1));
            stall_mode = $urandom_range(0, 2);
         end
         send_divide(2'($urandom_range(0, 3)), rand_operand(), rand_operand());
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      hold_cycles = 200;
      for (int i = 0; i < 150; i++)
         send_divide(2'($urandom_range(0, 3)), rand_operand(), rand_operand());
      drain_results();
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(600);
      test_backpressure();
      test_random(600);
      if (fail_count == 0) begin
         $display("int64_divide_remainder_trap_core verification clean");
      end else begin
         $display("int64_divide_remainder_trap_core verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("int64_divide_remainder_trap_core verification failed");
      $finish;
   end
endmodule
